@@ sv/rlcfs_pkg.sv @@
// Shared types and constants for the RGB LED chain frame serializer.
`timescale 1ns / 1ps

package rlcfs_pkg;

    // Field widths fixed by the item and register formats.
    localparam int CNT_W   = 9;
    localparam int HALF_W  = 16;
    localparam int IDX_W   = 8;
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // A frame holds at most 8 + 4 * 511 bytes, so the position needs 12 bits.
    localparam int POS_W = 12;

    // Codes of the kind field.
    localparam logic [KIND_W-1:0] KIND_SET  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_TICKS = 2'd2;

    // Header byte constants.
    localparam logic [7:0] HDR_BASE = 8'hFF;

    // Operation of a classified item.
    typedef enum logic [1:0] {
        OP_SET,
        OP_PUSH,
        OP_TICK,
        OP_NOP
    } op_t;

    // Classified item travelling from the front to the back.
    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  last_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } cmd_t;

    // Current configuration register values.
    typedef struct packed {
        logic [CNT_W-1:0]  led_count;
        logic              batch_mode;
        logic [HALF_W-1:0] half_period_ticks;
    } cfg_t;

    // Header byte: all ones with the top two bits of blue, green and red inverted.
    function automatic logic [7:0] make_header(input logic [COLOR_W-1:0] colour);
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        r = colour[3*CHAN_W-1:2*CHAN_W];
        g = colour[2*CHAN_W-1:CHAN_W];
        b = colour[CHAN_W-1:0];
        return HDR_BASE ^ {2'b00, b[7:6], g[7:6], r[7:6]};
    endfunction

endpackage

@@ sv/rlcfs_front.sv @@
// Front part: accepts items, classifies them and queues them for the back part.
`timescale 1ns / 1ps

module rlcfs_front
    import rlcfs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [IDX_W-1:0]  s_first_index,
    input  logic [IDX_W-1:0]  s_last_index,
    input  logic [CHAN_W-1:0] s_red,
    input  logic [CHAN_W-1:0] s_green,
    input  logic [CHAN_W-1:0] s_blue,
    input  logic              clearing,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_pop
);

    cmd_t       queue_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       decoded;
    logic       push;

    // Classify the incoming item by its kind.
    always_comb begin
        decoded.first_index = s_first_index;
        decoded.last_index  = s_last_index;
        decoded.red         = s_red;
        decoded.green       = s_green;
        decoded.blue        = s_blue;
        unique case (s_kind)
            KIND_SET:  decoded.op = OP_SET;
            KIND_PUSH: decoded.op = OP_PUSH;
            KIND_TICK: decoded.op = OP_TICK;
            default:   decoded.op = OP_NOP;
        endcase
    end

    // The queue takes items unless it is full or the store is being cleared.
    assign s_ready   = (count_reg != 2'd2) && !clearing;
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = queue_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            unique case ({push, cmd_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ sv/rlcfs_back.sv @@
// Back part: colour store, range fill engine and frame serializer.
`timescale 1ns / 1ps

module rlcfs_back
    import rlcfs_pkg::*;
#(
    parameter int MAX_LEDS = 256
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic clearing,
    output logic m_valid,
    input  logic m_ready,
    output logic m_clock_level,
    output logic m_data_level,
    output logic m_busy_res,
    output logic m_accepted
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_LOAD
    } state_t;

    logic [COLOR_W-1:0] mem [MAX_LEDS];
    logic [COLOR_W-1:0] rd_data_reg;

    state_t             state_reg;
    logic [AW-1:0]      clr_reg;
    logic [CNT_W-1:0]   fill_cur_reg;
    logic [CNT_W-1:0]   fill_last_reg;
    logic [COLOR_W-1:0] colour_reg;
    logic               sending_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [2:0]         bit_reg;
    logic [7:0]         shift_reg;
    logic               phase_reg;
    logic [HALF_W-1:0]  tick_reg;
    logic               out_valid_reg;
    logic               accepted_reg;

    logic [CNT_W-1:0]   eff_count;
    logic [CNT_W-1:0]   cap;
    logic [POS_W-1:0]   frame_bytes;
    logic [HALF_W-1:0]  half;
    logic [HALF_W-1:0]  tick_inc;
    logic [POS_W-1:0]   pos_inc;
    logic [CNT_W-1:0]   first_ext;
    logic [CNT_W-1:0]   last_ext;
    logic [CNT_W-1:0]   last_capped;
    logic [POS_W-1:0]   rel;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic [COLOR_W-1:0] wr_data;
    logic [7:0]         byte_val;
    logic               slot_free;

    // Effective chain length, frame length and half period.
    always_comb begin
        if (cfg.led_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (32'(cfg.led_count) > 32'(MAX_LEDS)) begin
            eff_count = CNT_W'(MAX_LEDS);
        end else begin
            eff_count = cfg.led_count;
        end
        cap         = eff_count - CNT_W'(1);
        frame_bytes = POS_W'({eff_count, 2'b00}) + POS_W'(8);
        half        = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;
        tick_inc    = tick_reg + HALF_W'(1);
        pos_inc     = pos_reg + POS_W'(1);
        first_ext   = CNT_W'(cmd.first_index);
        last_ext    = CNT_W'(cmd.last_index);
        last_capped = (last_ext > cap) ? cap : last_ext;
    end

    // Store address of the LED that the current frame byte belongs to.
    assign rel     = pos_reg - POS_W'(4);
    assign rd_addr = AW'(rel[POS_W-1:2]);

    // Frame byte at the current position: zero outside the LED section.
    always_comb begin
        if (pos_reg < POS_W'(4) || pos_reg >= frame_bytes - POS_W'(4)) begin
            byte_val = 8'h00;
        end else begin
            unique case (pos_reg[1:0])
                2'd0:    byte_val = make_header(rd_data_reg);
                2'd1:    byte_val = rd_data_reg[CHAN_W-1:0];
                2'd2:    byte_val = rd_data_reg[2*CHAN_W-1:CHAN_W];
                default: byte_val = rd_data_reg[3*CHAN_W-1:2*CHAN_W];
            endcase
        end
    end

    // Store write port: clearing pass or range fill.
    always_comb begin
        mem_we  = (state_reg == ST_CLEAR) || (state_reg == ST_FILL);
        wr_addr = (state_reg == ST_CLEAR) ? clr_reg : AW'(fill_cur_reg);
        wr_data = (state_reg == ST_CLEAR) ? '0 : colour_reg;
    end

    // Colour store with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // An item is taken only when its result has a free output slot.
    assign slot_free = !out_valid_reg || m_ready;
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid && slot_free;
    assign clearing  = (state_reg == ST_CLEAR);

    // Sequencer, serializer state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            sending_reg   <= 1'b0;
            pos_reg       <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            phase_reg     <= 1'b0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b1;
        end else begin
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == LAST_ADDR) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (cmd_pop) begin
                        accepted_reg <= 1'b1;
                        unique case (cmd.op)
                            OP_SET: begin
                                if (sending_reg) begin
                                    accepted_reg  <= 1'b0;
                                    out_valid_reg <= 1'b1;
                                end else begin
                                    fill_cur_reg  <= first_ext;
                                    fill_last_reg <= last_capped;
                                    colour_reg    <= {cmd.red, cmd.green, cmd.blue};
                                    if (first_ext <= last_capped) begin
                                        state_reg <= ST_FILL;
                                    end else begin
                                        // Empty range: nothing to write.
                                        out_valid_reg <= 1'b1;
                                        if (!cfg.batch_mode) begin
                                            sending_reg <= 1'b1;
                                            pos_reg     <= '0;
                                            bit_reg     <= '0;
                                            shift_reg   <= '0;
                                            phase_reg   <= 1'b1;
                                            tick_reg    <= '0;
                                        end
                                    end
                                end
                            end
                            OP_PUSH: begin
                                out_valid_reg <= 1'b1;
                                if (sending_reg) begin
                                    accepted_reg <= 1'b0;
                                end else begin
                                    sending_reg <= 1'b1;
                                    pos_reg     <= '0;
                                    bit_reg     <= '0;
                                    shift_reg   <= '0;
                                    phase_reg   <= 1'b1;
                                    tick_reg    <= '0;
                                end
                            end
                            OP_TICK: begin
                                out_valid_reg <= 1'b1;
                                if (sending_reg) begin
                                    if (tick_inc < half) begin
                                        tick_reg <= tick_inc;
                                    end else begin
                                        tick_reg <= '0;
                                        if (phase_reg) begin
                                            phase_reg <= 1'b0;
                                        end else if (bit_reg != 3'd7) begin
                                            bit_reg   <= bit_reg + 3'd1;
                                            phase_reg <= 1'b1;
                                        end else begin
                                            bit_reg <= '0;
                                            if (pos_inc >= frame_bytes) begin
                                                // End of frame: lines go low.
                                                sending_reg <= 1'b0;
                                                pos_reg     <= '0;
                                                shift_reg   <= '0;
                                                phase_reg   <= 1'b0;
                                            end else begin
                                                // Next byte needs a store read.
                                                pos_reg       <= pos_inc;
                                                phase_reg     <= 1'b1;
                                                out_valid_reg <= 1'b0;
                                                state_reg     <= ST_READ;
                                            end
                                        end
                                    end
                                end
                            end
                            default: begin
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_FILL: begin
                    fill_cur_reg <= fill_cur_reg + CNT_W'(1);
                    if (fill_cur_reg == fill_last_reg) begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                        if (!cfg.batch_mode) begin
                            sending_reg <= 1'b1;
                            pos_reg     <= '0;
                            bit_reg     <= '0;
                            shift_reg   <= '0;
                            phase_reg   <= 1'b1;
                            tick_reg    <= '0;
                        end
                    end
                end
                ST_READ: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    shift_reg     <= byte_val;
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The serializer state is frozen while a result waits to be taken.
    assign m_valid       = out_valid_reg;
    assign m_clock_level = phase_reg;
    assign m_data_level  = shift_reg[~bit_reg];
    assign m_busy_res    = sending_reg;
    assign m_accepted    = accepted_reg;

endmodule

@@ sv/rgb_led_chain_frame_serializer.sv @@
// Top level of the RGB LED chain frame serializer.
`timescale 1ns / 1ps

// Keeps one 24-bit colour per LED and sends frames of the two-wire clock/data
// LED protocol, with the serial clock timed by tick items. Every item gets exactly
// one result carrying the line levels, the busy flag and the accepted flag.
// After reset the colour store is swept to zero, one entry per cycle, so no
// item is accepted until the sweep ends. A tick that starts a new byte
// first fetches the colour from the store through its registered read port;
// a set item has the fill engine write its range, one entry per cycle. A
// two-item queue sits between the input side and the sequencer, and the
// sequencer takes the next item only when the result register is empty or
// its result is being taken in that cycle.
module rgb_led_chain_frame_serializer
    import rlcfs_pkg::*;
#(
    parameter int MAX_LEDS = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [IDX_W-1:0]      s_first_index,
    input  logic [IDX_W-1:0]      s_last_index,
    input  logic [CHAN_W-1:0]     s_red,
    input  logic [CHAN_W-1:0]     s_green,
    input  logic [CHAN_W-1:0]     s_blue,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_clock_level,
    output logic                  m_data_level,
    output logic                  m_busy_res,
    output logic                  m_accepted,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic clearing;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.led_count         <= CNT_W'(1);
            cfg_reg.batch_mode        <= 1'b0;
            cfg_reg.half_period_ticks <= HALF_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_LED_COUNT:  cfg_reg.led_count         <= cfg_wdata[CNT_W-1:0];
                CFG_BATCH_MODE: cfg_reg.batch_mode        <= cfg_wdata[0];
                CFG_HALF_TICKS: cfg_reg.half_period_ticks <= cfg_wdata[HALF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input side: classification and queue.
    rlcfs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_first_index (s_first_index),
        .s_last_index  (s_last_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .clearing      (clearing),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    // Execution side: store, fill engine and serializer.
    rlcfs_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .clearing      (clearing),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_clock_level (m_clock_level),
        .m_data_level  (m_data_level),
        .m_busy_res    (m_busy_res),
        .m_accepted    (m_accepted)
    );

    // A refusal only happens while a frame is on the wire.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_accepted |-> m_busy_res)
        else $error("item refused while no frame was being sent");

    // Outside a frame both lines rest low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> !m_clock_level && !m_data_level)
        else $error("serial lines not low while idle");

    // No item enters while the store is being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready && !m_valid)
        else $error("item traffic during the clearing pass");

endmodule
